// ===== src/ssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the stack sort checker.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int START_BITS = 16;
   localparam int SEEN_BITS  = 17;
   localparam logic [SEEN_BITS-1:0] SEEN_MAX = {SEEN_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_VERDICT
   } ssc_state_type;

   typedef struct packed {
      logic end_of_run;
      logic sorted_ok;
      logic is_verdict;
   } ssc_flags_type;

endpackage

// ===== src/ssc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ssc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_out_reg
// Result register of the response channel; frees as the transaction is taken.
// ----------------------------------------------------------------------------
module ssc_out_reg
   import ssc_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [VALUE_BITS-1:0]               load_value,
   input  ssc_flags_type                       load_flags,
   output logic                                can_load,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff;
   ssc_flags_type         flags_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_value;
         flags_ff <= load_flags;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = DATA_W'(value_ff);
   assign rsp_tuser  = {flags_ff.sorted_ok, flags_ff.is_verdict};
   assign rsp_tlast  = flags_ff.end_of_run;

endmodule

// ===== src/stack_sort_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_sort_checker_core
// One-stack sortability check of a permutation, stack held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one value of the sequence per transaction; req_tlast marks
//   the final value. rsp_* returns the values in sorted order as they leave,
//   then one verdict transaction after the final value (tdata zero, tuser[0]
//   set, tuser[1] the verdict). rsp_tlast marks the last result of an input.
//   csr_wen/csr_wdata write the start value; write only while idle.
// Timing:
//   An input is taken only in the idle state. Popped values are emitted from
//   the pop state; the first comes from the top register while the RAM reads
//   the entry below it. The verdict is emitted from the verdict state. Each
//   value is popped at most once. The first result is registered and appears
//   in the cycle after acceptance.
// Reset:
//   Synchronous, clears the run state and sets the start value to 1. The
//   stack RAM needs no clearing; only entries below the count are read.
// Back-pressure:
//   A held result stalls the controller; no input is taken until the result
//   register can accept the next result.
// ----------------------------------------------------------------------------
module stack_sort_checker_core
   import ssc_pkg::*;
#(
   parameter int STACK_DEPTH = 32,
   parameter int VALUE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [START_BITS-1:0]               csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // in_value
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_value
   output logic [((VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // sorted_ok (bit 1), is_verdict (bit 0)
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int EXP_W  = (VALUE_BITS > START_BITS ? VALUE_BITS : START_BITS) + 1;
   localparam int CMP_W  = (EXP_W > SEEN_BITS ? EXP_W : SEEN_BITS) + 2;

   ssc_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [SEEN_BITS-1:0]  seen_ff, seen_in;
   logic                  failed_ff, failed_in;
   logic                  last_ff, last_in;
   logic [START_BITS-1:0] start_ff, start_in;
   logic [VALUE_BITS-1:0] top_ff, top_in;
   logic [VALUE_BITS-1:0] pend_ff, pend_in;

   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] rd_data;

   logic                  emit, can_emit;
   logic [VALUE_BITS-1:0] emit_value;
   ssc_flags_type         emit_flags;

   logic [VALUE_BITS-1:0] in_value;
   logic                  accept, more, ok;

   assign in_value = req_tdata[VALUE_BITS-1:0];
   assign accept   = req_tvalid && req_tready;
   assign ok       = !failed_ff && (count_ff == '0) &&
                     (CMP_W'(exp_ff) == CMP_W'(start_ff) + CMP_W'(seen_ff));

   ssc_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(top_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ssc_out_reg #(
      .VALUE_BITS(VALUE_BITS)
   ) u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_value(emit_value),
      .load_flags(emit_flags),
      .can_load  (can_emit),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      exp_in     = exp_ff;
      seen_in    = seen_ff;
      failed_in  = failed_ff;
      last_in    = last_ff;
      start_in   = start_ff;
      top_in     = top_ff;
      pend_in    = pend_ff;
      wr_en      = 1'b0;
      wr_addr    = ADDR_W'(count_ff - CNT_W'(1));
      rd_en      = 1'b0;
      rd_addr    = ADDR_W'(count_ff - CNT_W'(2));
      emit       = 1'b0;
      emit_value = '0;
      emit_flags = '0;
      more       = 1'b0;
      req_tready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = can_emit;
            if (accept) begin
               last_in = req_tlast;
               if (seen_ff != SEEN_MAX) begin
                  seen_in = seen_ff + SEEN_BITS'(1);
               end
               state_in = req_tlast ? ST_VERDICT : ST_IDLE;
               if (!failed_ff) begin
                  if (EXP_W'(in_value) == exp_ff) begin
                     more       = (count_ff != '0) &&
                                  (EXP_W'(top_ff) == exp_ff + EXP_W'(1));
                     emit       = 1'b1;
                     emit_value = in_value;
                     emit_flags.end_of_run = !more && !req_tlast;
                     exp_in     = exp_ff + EXP_W'(1);
                     if (more) begin
                        pend_in  = top_ff;
                        count_in = count_ff - CNT_W'(1);
                        exp_in   = exp_ff + EXP_W'(2);
                        rd_en    = (count_ff >= CNT_W'(2));
                        state_in = ST_POP;
                     end
                  end else if ((count_ff != '0) && (top_ff < in_value)) begin
                     failed_in = 1'b1;
                  end else if (count_ff >= CNT_W'(STACK_DEPTH)) begin
                     failed_in = 1'b1;
                  end else begin
                     wr_en    = (count_ff != '0);
                     top_in   = in_value;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_POP: begin
            if (can_emit) begin
               more       = (count_ff != '0) && (EXP_W'(rd_data) == exp_ff);
               emit       = 1'b1;
               emit_value = pend_ff;
               emit_flags.end_of_run = !more && !last_ff;
               top_in     = rd_data;
               if (more) begin
                  pend_in  = rd_data;
                  count_in = count_ff - CNT_W'(1);
                  exp_in   = exp_ff + EXP_W'(1);
                  rd_en    = (count_ff >= CNT_W'(2));
               end else begin
                  state_in = last_ff ? ST_VERDICT : ST_IDLE;
               end
            end
         end
         ST_VERDICT: begin
            if (can_emit) begin
               emit                  = 1'b1;
               emit_flags.is_verdict = 1'b1;
               emit_flags.sorted_ok  = ok;
               emit_flags.end_of_run = 1'b1;
               count_in  = '0;
               exp_in    = EXP_W'(start_ff);
               seen_in   = '0;
               failed_in = 1'b0;
               last_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wen) begin
         start_in = csr_wdata;
         if (seen_ff == '0) begin
            exp_in = EXP_W'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         exp_ff    <= EXP_W'(1);
         seen_ff   <= '0;
         failed_ff <= 1'b0;
         last_ff   <= 1'b0;
         start_ff  <= START_BITS'(1);
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         exp_ff    <= exp_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
         last_ff   <= last_in;
         start_ff  <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      pend_ff <= pend_in;
   end

endmodule

// ===== src/ssc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the stack sort checker's response channel.
// ----------------------------------------------------------------------------
module ssc_checker #(
   parameter int VALUE_BITS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast
);

   // hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("verdict not last or data not zero");

   a_ok_only_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("sorted flag on a value transaction");

endmodule

bind stack_sort_checker_core ssc_checker #(
   .VALUE_BITS(VALUE_BITS)
) u_ssc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);
